// File: hw/rtl/assert_macros.svh
// concurrent assertion helpers for the frame receiver
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("frame receiver: invariant broken");

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver: implication broken");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver: next-cycle check broken");

`else

`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/sdfr_pkg.sv
package sdfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 14;
  localparam int SEQ_W   = 8;
  localparam int EXP_W   = 7;
  localparam int LOSS_W  = 16;
  localparam int POS_W   = 4;

  localparam logic [BYTE_W-1:0]  START_BYTE      = 8'h80;
  localparam logic [BYTE_W-1:0]  DIGIT_ONE       = 8'h31;
  localparam logic [BYTE_W-1:0]  DIGIT_NINE      = 8'h39;
  localparam logic [EXP_W-1:0]   SEQ_WRAP        = 7'h7F;
  localparam logic [LOSS_W-1:0]  LOSS_MAX        = 16'hFFFF;
  localparam logic [SEQ_W-1:0]   GAP_LIMIT_RESET = 8'd10;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_IDLE      = 4'd0;
  localparam logic [POS_W-1:0] POS_SEQ       = 4'd1;
  localparam logic [POS_W-1:0] POS_CMD_LAST  = 4'd5;
  localparam logic [POS_W-1:0] POS_LAST      = 4'd9;

  typedef enum logic [2:0] {
    ST_TAKEN = 3'd0,
    ST_DONE  = 3'd1,
    ST_LOST  = 3'd2,
    ST_STRAY = 3'd3,
    ST_FATAL = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [VALUE_W-1:0]  command_value;
    logic [VALUE_W-1:0]  duration_value;
    logic [SEQ_W-1:0]    frame_sequence;
    logic [LOSS_W-1:0]   loss_total;
  } result_t;

endpackage

// File: hw/rtl/sdfr_in_stage.sv
module sdfr_in_stage
  import sdfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              take,
  output logic              held_valid,
  output logic [BYTE_W-1:0] held_byte
);

  logic accept;

  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// File: hw/rtl/sdfr_core.sv
`include "assert_macros.svh"

module sdfr_core
  import sdfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [SEQ_W-1:0]  limit,
  output result_t           result
);

  logic [POS_W-1:0]   position, position_next;
  logic [SEQ_W-1:0]   seen_seq, seen_seq_next;
  logic [EXP_W-1:0]   expected, expected_next;
  logic [VALUE_W-1:0] cmd_acc, cmd_acc_next;
  logic [VALUE_W-1:0] dur_acc, dur_acc_next;
  logic [LOSS_W-1:0]  loss, loss_next;

  logic [3:0]         digit;
  logic [VALUE_W-1:0] cmd_step, dur_step;
  logic [SEQ_W-1:0]   gap;
  logic [SEQ_W-1:0]   loss_add;
  logic [LOSS_W:0]    loss_sum;
  logic [EXP_W-1:0]   seq_inc;

  // anything outside '1'..'9' decodes as zero
  assign digit = (rx_byte >= DIGIT_ONE && rx_byte <= DIGIT_NINE) ? rx_byte[3:0] : 4'd0;

  // times ten as two shifts
  assign cmd_step = {cmd_acc[VALUE_W-4:0], 3'b000} + {cmd_acc[VALUE_W-2:0], 1'b0}
                    + {{(VALUE_W-4){1'b0}}, digit};
  assign dur_step = {dur_acc[VALUE_W-4:0], 3'b000} + {dur_acc[VALUE_W-2:0], 1'b0}
                    + {{(VALUE_W-4){1'b0}}, digit};

  assign gap      = seen_seq - {1'b0, expected};
  assign loss_sum = {1'b0, loss} + {{(LOSS_W+1-SEQ_W){1'b0}}, loss_add};
  assign seq_inc  = seen_seq[EXP_W-1:0] + 7'd1;

  always_comb begin
    position_next = position;
    seen_seq_next = seen_seq;
    expected_next = expected;
    cmd_acc_next  = cmd_acc;
    dur_acc_next  = dur_acc;
    loss_add      = '0;
    result        = '0;
    result.status = ST_TAKEN;

    if (rx_byte == START_BYTE) begin
      if (position != POS_IDLE) begin
        loss_add      = 8'd1;
        result.status = ST_LOST;
      end
      position_next = POS_SEQ;
      cmd_acc_next  = '0;
      dur_acc_next  = '0;
    end else if (position == POS_IDLE || position > POS_LAST) begin
      loss_add      = 8'd1;
      position_next = POS_IDLE;
      result.status = ST_STRAY;
    end else begin
      if (position == POS_SEQ) begin
        seen_seq_next = rx_byte;
      end else if (position <= POS_CMD_LAST) begin
        cmd_acc_next = cmd_step;
      end else begin
        dur_acc_next = dur_step;
      end
      position_next = position + 4'd1;

      // tenth byte closes the frame
      if (position == POS_LAST) begin
        position_next         = POS_IDLE;
        result.frame_sequence = seen_seq;
        if (gap >= limit) begin
          result.status = ST_FATAL;
        end else begin
          loss_add              = gap;
          result.status         = ST_DONE;
          result.command_value  = cmd_acc;
          result.duration_value = dur_step;
          expected_next         = (seq_inc == SEQ_WRAP) ? '0 : seq_inc;
        end
      end
    end

    loss_next         = loss_sum[LOSS_W] ? LOSS_MAX : loss_sum[LOSS_W-1:0];
    result.loss_total = loss_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_IDLE;
      seen_seq <= '0;
      expected <= '0;
      cmd_acc  <= '0;
      dur_acc  <= '0;
      loss     <= '0;
    end else if (take) begin
      position <= position_next;
      seen_seq <= seen_seq_next;
      expected <= expected_next;
      cmd_acc  <= cmd_acc_next;
      dur_acc  <= dur_acc_next;
      loss     <= loss_next;
    end
  end

  `ASSERT_HOLDS(a_position_range, clk, rst, position <= POS_LAST)
  `ASSERT_HOLDS(a_expected_wrap, clk, rst, expected != SEQ_WRAP)
  `ASSERT_NEXT(a_loss_monotonic, clk, rst, 1'b1, loss >= $past(loss))
  `ASSERT_SAME(a_done_at_last, clk, rst, take && result.status == ST_DONE,
               position == POS_LAST)

endmodule

// File: hw/rtl/sdfr_out_stage.sv
module sdfr_out_stage
  import sdfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t held
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= result;
    end
  end

endmodule

// File: hw/rtl/sequenced_decimal_frame_receiver.sv
// Frame receiver for 10-byte decimal command frames (start byte 0x80, sequence
// byte, four command digits, four duration digits). One byte is taken every
// clock cycle while in_stall is low, and every byte gives one result beat: it
// passes through the input register, then through the decode into the result
// register. The decode is a single pass over the frame state registers, which
// are updated once per byte. While a result beat waits, the input register
// still takes one more byte; in_stall rises only when both registers are full
// and out_stall is high. The gap limit is written through the cfg channel
// (cfg_ready is always high) and should be changed only while no byte is in
// flight.
module sequenced_decimal_frame_receiver
  import sdfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SEQ_W-1:0]   gap_limit,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [VALUE_W-1:0] command_value,
  output logic [VALUE_W-1:0] duration_value,
  output logic [SEQ_W-1:0]   frame_sequence,
  output logic [LOSS_W-1:0]  loss_total
);

  logic [SEQ_W-1:0]  limit;
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              out_free;
  logic              take;
  result_t           result;
  result_t           held;

  assign cfg_ready = 1'b1;
  assign take      = held_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= GAP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= gap_limit;
    end
  end

  sdfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  sdfr_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (held_byte),
    .limit   (limit),
    .result  (result)
  );

  sdfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign status         = held.status;
  assign command_value  = held.command_value;
  assign duration_value = held.duration_value;
  assign frame_sequence = held.frame_sequence;
  assign loss_total     = held.loss_total;

endmodule
